// ===== rtl/tdmc_pkg.sv =====
// Shared types, codes and constants of the timed door motion controller.
`timescale 1ns / 1ps

package tdmc_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TravelW  = 20;
  localparam int unsigned SettleW  = 16;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CFG_TRAVEL_TIME = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_TIME = 1'b1;

  localparam logic [TravelW-1:0] TRAVEL_RESET = 20'd10000;
  localparam logic [SettleW-1:0] SETTLE_RESET = 16'd1000;
  localparam logic [SettleW-1:0] SETTLE_MIN   = 16'd250;
  localparam logic [SettleW-1:0] SETTLE_MAX   = 16'd5000;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_OPEN   = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_TOGGLE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    M_IDLE_UNKNOWN = 3'd0,
    M_IDLE_OPEN    = 3'd1,
    M_IDLE_CLOSED  = 3'd2,
    M_MOVING_OPEN  = 3'd3,
    M_MOVING_CLOSE = 3'd4,
    M_POSTCLOSE    = 3'd5
  } motion_e;

  typedef enum logic [1:0] {
    POS_UNKNOWN = 2'd0,
    POS_OPEN    = 2'd1,
    POS_CLOSED  = 2'd2
  } pos_e;

  typedef enum logic [1:0] {
    LED_OFF    = 2'd0,
    LED_STEADY = 2'd1,
    LED_FLASH  = 2'd2,
    LED_FADE   = 2'd3
  } led_mode_e;

  typedef struct packed {
    motion_e          motion;
    pos_e             settled;
    logic [TimeW-1:0] start_stamp;
    logic             start_valid;
    logic             motor_enabled;
    logic             drive_open;
  } door_state_t;

  typedef struct packed {
    motion_e   motion_state;
    pos_e      settled_position;
    logic      motor_on;
    logic      motor_dir_open;
    logic      lock_release_pulse;
    logic      lock_engage_pulse;
    led_mode_e led_mode;
    logic      led_red;
  } result_t;

endpackage

// ===== rtl/tdmc_cmd_if.sv =====
// Command channel carrying one door command beat.
`timescale 1ns / 1ps

interface tdmc_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tdmc_pkg::CmdW-1:0]    cmd;
  logic [tdmc_pkg::TimeW-1:0]   now_time;

  modport source (output valid, output cmd, output now_time, input ready);
  modport sink (input valid, input cmd, input now_time, output ready);
endinterface

// ===== rtl/tdmc_res_if.sv =====
// Result channel carrying one actuator drive beat.
`timescale 1ns / 1ps

interface tdmc_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] motion_state;
  logic [1:0] settled_position;
  logic       motor_on;
  logic       motor_dir_open;
  logic       lock_release_pulse;
  logic       lock_engage_pulse;
  logic [1:0] led_mode;
  logic       led_red;

  modport source (
    output valid, output motion_state, output settled_position, output motor_on,
    output motor_dir_open, output lock_release_pulse, output lock_engage_pulse,
    output led_mode, output led_red, input ready
  );
  modport sink (
    input valid, input motion_state, input settled_position, input motor_on,
    input motor_dir_open, input lock_release_pulse, input lock_engage_pulse,
    input led_mode, input led_red, output ready
  );
endinterface

// ===== rtl/tdmc_step.sv =====
// Next-state and result logic for one door command.
`timescale 1ns / 1ps

module tdmc_step (
  input  tdmc_pkg::door_state_t            cur_i,
  input  logic [tdmc_pkg::TravelW-1:0]     travel_time_i,
  input  logic [tdmc_pkg::SettleW-1:0]     settle_time_i,
  input  tdmc_pkg::cmd_e                   cmd_i,
  input  logic [tdmc_pkg::TimeW-1:0]       now_time_i,
  output tdmc_pkg::door_state_t            nxt_o,
  output tdmc_pkg::result_t                res_o
);

  logic [tdmc_pkg::TimeW-1:0]   elapsed;
  logic [tdmc_pkg::SettleW-1:0] settle_c;
  logic                         travel_done;
  logic                         settle_done;
  logic                         go;
  logic                         to_open;
  logic                         engage;

  assign elapsed     = now_time_i - cur_i.start_stamp;
  assign travel_done = elapsed >= {{(tdmc_pkg::TimeW - tdmc_pkg::TravelW){1'b0}}, travel_time_i};

  always_comb begin
    if (settle_time_i < tdmc_pkg::SETTLE_MIN) begin
      settle_c = tdmc_pkg::SETTLE_MIN;
    end else if (settle_time_i > tdmc_pkg::SETTLE_MAX) begin
      settle_c = tdmc_pkg::SETTLE_MAX;
    end else begin
      settle_c = settle_time_i;
    end
  end

  assign settle_done = elapsed >= {{(tdmc_pkg::TimeW - tdmc_pkg::SettleW){1'b0}}, settle_c};

  always_comb begin
    nxt_o   = cur_i;
    go      = 1'b0;
    to_open = 1'b0;
    engage  = 1'b0;
    unique case (cmd_i)
      tdmc_pkg::CMD_TICK: begin
        unique case (cur_i.motion)
          tdmc_pkg::M_MOVING_OPEN, tdmc_pkg::M_MOVING_CLOSE: begin
            if (!cur_i.start_valid) begin
              nxt_o.start_stamp = now_time_i;
              nxt_o.start_valid = 1'b1;
            end else if (travel_done) begin
              nxt_o.motor_enabled = 1'b0;
              if (cur_i.motion == tdmc_pkg::M_MOVING_OPEN) begin
                nxt_o.start_valid = 1'b0;
                nxt_o.start_stamp = '0;
                nxt_o.settled     = tdmc_pkg::POS_OPEN;
                nxt_o.motion      = tdmc_pkg::M_IDLE_OPEN;
              end else begin
                nxt_o.start_stamp = now_time_i;
                nxt_o.start_valid = 1'b1;
                nxt_o.motion      = tdmc_pkg::M_POSTCLOSE;
              end
            end
          end
          tdmc_pkg::M_POSTCLOSE: begin
            if (settle_done) begin
              nxt_o.start_valid = 1'b0;
              nxt_o.start_stamp = '0;
              nxt_o.settled     = tdmc_pkg::POS_CLOSED;
              nxt_o.motion      = tdmc_pkg::M_IDLE_CLOSED;
              engage            = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      tdmc_pkg::CMD_OPEN: begin
        go      = 1'b1;
        to_open = 1'b1;
      end
      tdmc_pkg::CMD_CLOSE: begin
        go      = 1'b1;
        to_open = 1'b0;
      end
      tdmc_pkg::CMD_TOGGLE: begin
        go      = cur_i.motion != tdmc_pkg::M_POSTCLOSE;
        to_open = (cur_i.motion == tdmc_pkg::M_IDLE_CLOSED) ||
                  (cur_i.motion == tdmc_pkg::M_MOVING_CLOSE);
      end
    endcase

    if (go) begin
      nxt_o.start_valid   = 1'b0;
      nxt_o.start_stamp   = '0;
      nxt_o.settled       = tdmc_pkg::POS_UNKNOWN;
      nxt_o.drive_open    = to_open;
      nxt_o.motor_enabled = 1'b1;
      nxt_o.motion        = to_open ? tdmc_pkg::M_MOVING_OPEN : tdmc_pkg::M_MOVING_CLOSE;
    end
  end

  always_comb begin
    res_o.motion_state       = nxt_o.motion;
    res_o.settled_position   = nxt_o.settled;
    res_o.motor_on           = nxt_o.motor_enabled;
    res_o.motor_dir_open     = nxt_o.drive_open;
    res_o.lock_release_pulse = go;
    res_o.lock_engage_pulse  = engage;
    unique case (nxt_o.motion)
      tdmc_pkg::M_IDLE_OPEN, tdmc_pkg::M_IDLE_CLOSED: begin
        res_o.led_mode = tdmc_pkg::LED_OFF;
        res_o.led_red  = 1'b0;
      end
      tdmc_pkg::M_MOVING_OPEN: begin
        res_o.led_mode = tdmc_pkg::LED_FADE;
        res_o.led_red  = 1'b0;
      end
      tdmc_pkg::M_MOVING_CLOSE: begin
        res_o.led_mode = tdmc_pkg::LED_FADE;
        res_o.led_red  = 1'b1;
      end
      tdmc_pkg::M_POSTCLOSE: begin
        res_o.led_mode = tdmc_pkg::LED_STEADY;
        res_o.led_red  = 1'b1;
      end
      default: begin
        res_o.led_mode = tdmc_pkg::LED_FLASH;
        res_o.led_red  = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/timed_door_motion_controller.sv =====
// Top level of the timed door motion controller.
`timescale 1ns / 1ps

// Each command beat is applied to the door state in the cycle it is accepted, and its
// result beat is registered in the output register, or in the skid register while the
// output register holds a pending result. This two-entry output buffer lets the block
// take one command per cycle as long as the skid register is free, so a single stalled
// result does not hold up the command side. Travel and settle times are in the units of
// the tick timestamps and are compared against the wrap-safe difference between the
// current tick and the stored start stamp.
module timed_door_motion_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tdmc_cmd_if.sink                           cmd_i,
  tdmc_res_if.source                         res_o,
  input  logic                               cfg_we_i,
  input  logic [tdmc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tdmc_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic [tdmc_pkg::TravelW-1:0] travel_q;
  logic [tdmc_pkg::SettleW-1:0] settle_q;
  tdmc_pkg::door_state_t        state_q, state_d;
  tdmc_pkg::result_t            res_d, out_q, skid_q;
  logic                         out_valid_q, skid_valid_q;
  logic                         push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      travel_q <= tdmc_pkg::TRAVEL_RESET;
      settle_q <= tdmc_pkg::SETTLE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdmc_pkg::CFG_TRAVEL_TIME: travel_q <= cfg_data_i[tdmc_pkg::TravelW-1:0];
        tdmc_pkg::CFG_SETTLE_TIME: settle_q <= cfg_data_i[tdmc_pkg::SettleW-1:0];
      endcase
    end
  end

  tdmc_step u_step (
    .cur_i         (state_q),
    .travel_time_i (travel_q),
    .settle_time_i (settle_q),
    .cmd_i         (tdmc_pkg::cmd_e'(cmd_i.cmd)),
    .now_time_i    (cmd_i.now_time),
    .nxt_o         (state_d),
    .res_o         (res_d)
  );

  assign cmd_i.ready = !skid_valid_q;
  assign push        = cmd_i.valid && !skid_valid_q;
  assign pop         = out_valid_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.motion        <= tdmc_pkg::M_IDLE_UNKNOWN;
      state_q.settled       <= tdmc_pkg::POS_UNKNOWN;
      state_q.start_stamp   <= '0;
      state_q.start_valid   <= 1'b0;
      state_q.motor_enabled <= 1'b0;
      state_q.drive_open    <= 1'b0;
    end else if (push) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= push;
        end else begin
          out_valid_q <= push;
        end
      end else if (push) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= res_d;
        end
      end else if (push) begin
        out_q <= res_d;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.motion_state       = out_q.motion_state;
  assign res_o.settled_position   = out_q.settled_position;
  assign res_o.motor_on           = out_q.motor_on;
  assign res_o.motor_dir_open     = out_q.motor_dir_open;
  assign res_o.lock_release_pulse = out_q.lock_release_pulse;
  assign res_o.lock_engage_pulse  = out_q.lock_engage_pulse;
  assign res_o.led_mode           = out_q.led_mode;
  assign res_o.led_red            = out_q.led_red;

endmodule
